/* rtl/fmts_pkg.sv */
// Shared types and constants for the FM tuner seek controller.
// No dependencies; used by every module of the block.
package fmts_pkg;

  typedef struct packed {
    logic [15:0] now_ticks;
    logic        up_pressed;
    logic        down_pressed;
    logic        tuner_locked;
    logic        station_present;
    logic        freq_too_high;
    logic        freq_not_low;
  } in_item_t;

  typedef struct packed {
    logic [16:0] frequency_khz;
    logic        tune_request;
    logic        display_update;
    logic        seek_marker;
    logic [1:0]  seek_phase;
  } out_item_t;

  typedef struct packed {
    logic [16:0] start_freq_khz;
    logic [16:0] band_low_khz;
    logic [16:0] band_high_khz;
    logic [9:0]  seek_step_khz;
    logic [15:0] fast_hold_ticks;
    logic [15:0] step_interval_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] station_timeout_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_START_FREQ    = 3'd0,
    REG_BAND_LOW      = 3'd1,
    REG_BAND_HIGH     = 3'd2,
    REG_SEEK_STEP     = 3'd3,
    REG_FAST_HOLD     = 3'd4,
    REG_STEP_INTERVAL = 3'd5,
    REG_SETTLE        = 3'd6,
    REG_STATION_TMO   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_HOLD  = 4'b0001,
    PH_TUNE  = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_FAST  = 4'b1000
  } phase_t;

  localparam logic [1:0] PHASE_CODE_HOLD  = 2'd0;
  localparam logic [1:0] PHASE_CODE_TUNE  = 2'd1;
  localparam logic [1:0] PHASE_CODE_CHECK = 2'd2;
  localparam logic [1:0] PHASE_CODE_FAST  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [16:0] RST_START_FREQ    = 17'd87500;
  localparam logic [16:0] RST_BAND_LOW      = 17'd87500;
  localparam logic [16:0] RST_BAND_HIGH     = 17'd108000;
  localparam logic [9:0]  RST_SEEK_STEP     = 10'd100;
  localparam logic [15:0] RST_FAST_HOLD     = 16'd3906;
  localparam logic [15:0] RST_STEP_INTERVAL = 16'd1562;
  localparam logic [15:0] RST_SETTLE        = 16'd78;
  localparam logic [15:0] RST_STATION_TMO   = 16'd781;

  // x % 50 == 0  <=>  x even and (x/2) * inv(25) mod 2^16 <= floor((2^16-1)/25)
  localparam logic [15:0] INV25_MOD16  = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT  = 16'd2621;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_HOLD:  code = PHASE_CODE_HOLD;
      PH_TUNE:  code = PHASE_CODE_TUNE;
      PH_CHECK: code = PHASE_CODE_CHECK;
      PH_FAST:  code = PHASE_CODE_FAST;
      default:  code = PHASE_CODE_HOLD;
    endcase
    return code;
  endfunction

endpackage

/* rtl/fmts_cfg.sv */
// Configuration register file of the seek controller, APB-style access.
// Depends on fmts_pkg.
module fmts_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fmts_pkg::cfg_t     cfg
);

  fmts_pkg::cfg_t   cfg_r;
  fmts_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = fmts_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_freq_khz        <= fmts_pkg::RST_START_FREQ;
      cfg_r.band_low_khz          <= fmts_pkg::RST_BAND_LOW;
      cfg_r.band_high_khz         <= fmts_pkg::RST_BAND_HIGH;
      cfg_r.seek_step_khz         <= fmts_pkg::RST_SEEK_STEP;
      cfg_r.fast_hold_ticks       <= fmts_pkg::RST_FAST_HOLD;
      cfg_r.step_interval_ticks   <= fmts_pkg::RST_STEP_INTERVAL;
      cfg_r.settle_ticks          <= fmts_pkg::RST_SETTLE;
      cfg_r.station_timeout_ticks <= fmts_pkg::RST_STATION_TMO;
    end else if (wr_en) begin
      case (idx)
        fmts_pkg::REG_START_FREQ:    cfg_r.start_freq_khz        <= pwdata[16:0];
        fmts_pkg::REG_BAND_LOW:      cfg_r.band_low_khz          <= pwdata[16:0];
        fmts_pkg::REG_BAND_HIGH:     cfg_r.band_high_khz         <= pwdata[16:0];
        fmts_pkg::REG_SEEK_STEP:     cfg_r.seek_step_khz         <= pwdata[9:0];
        fmts_pkg::REG_FAST_HOLD:     cfg_r.fast_hold_ticks       <= pwdata[15:0];
        fmts_pkg::REG_STEP_INTERVAL: cfg_r.step_interval_ticks   <= pwdata[15:0];
        fmts_pkg::REG_SETTLE:        cfg_r.settle_ticks          <= pwdata[15:0];
        fmts_pkg::REG_STATION_TMO:   cfg_r.station_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fmts_pkg::REG_START_FREQ:    prdata = {15'd0, cfg_r.start_freq_khz};
      fmts_pkg::REG_BAND_LOW:      prdata = {15'd0, cfg_r.band_low_khz};
      fmts_pkg::REG_BAND_HIGH:     prdata = {15'd0, cfg_r.band_high_khz};
      fmts_pkg::REG_SEEK_STEP:     prdata = {22'd0, cfg_r.seek_step_khz};
      fmts_pkg::REG_FAST_HOLD:     prdata = {16'd0, cfg_r.fast_hold_ticks};
      fmts_pkg::REG_STEP_INTERVAL: prdata = {16'd0, cfg_r.step_interval_ticks};
      fmts_pkg::REG_SETTLE:        prdata = {16'd0, cfg_r.settle_ticks};
      fmts_pkg::REG_STATION_TMO:   prdata = {16'd0, cfg_r.station_timeout_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/fmts_core.sv */
// Seek state machine and frequency arithmetic; holds the seek state registers
// and computes one result per processed sample. Depends on fmts_pkg.
module fmts_core #(
  parameter int FAST_INTERVAL_TICKS = 195
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  fmts_pkg::in_item_t  item,
  input  fmts_pkg::cfg_t      cfg,
  output fmts_pkg::out_item_t result
);

  localparam logic [15:0] FAST_IVL = 16'(FAST_INTERVAL_TICKS);

  fmts_pkg::phase_t   phase_r, phase_nxt;
  logic [16:0]        freq_r, freq_nxt;
  logic signed [10:0] step_r, step_nxt;
  logic [15:0]        last_r, last_nxt;
  logic               first_r;

  logic [16:0]        freq_cur;
  logic [15:0]        elapsed;
  logic signed [10:0] quarter;
  logic signed [10:0] delta;
  logic signed [18:0] sum;
  logic [16:0]        stepped;
  logic [15:0]        div25_prod;
  logic               on_50k;
  logic               step_pos, step_neg;
  logic               key_any;
  logic               tune, disp, marker;

  assign freq_cur = first_r ? cfg.start_freq_khz : freq_r;
  assign elapsed  = item.now_ticks - last_r;
  assign key_any  = item.up_pressed || item.down_pressed;
  assign step_neg = step_r[10];
  assign step_pos = !step_r[10] && (|step_r);

  // quarter step, truncated toward zero
  assign quarter = (step_r >>> 2) + $signed(11'(step_neg && (|step_r[1:0])));
  assign delta   = (phase_r == fmts_pkg::PH_FAST) ? quarter : step_r;

  assign sum = $signed({2'b00, freq_cur}) + 19'(delta);

  always_comb begin
    if (sum > $signed({2'b00, cfg.band_high_khz})) begin
      stepped = cfg.band_low_khz;
    end else if (sum < $signed({2'b00, cfg.band_low_khz})) begin
      stepped = cfg.band_high_khz;
    end else begin
      stepped = sum[16:0];
    end
  end

  assign div25_prod = 16'(freq_cur[16:1] * fmts_pkg::INV25_MOD16);
  assign on_50k     = !freq_cur[0] && (div25_prod <= fmts_pkg::DIV25_LIMIT);

  always_comb begin
    phase_nxt = phase_r;
    freq_nxt  = freq_cur;
    step_nxt  = step_r;
    last_nxt  = last_r;
    tune      = first_r;
    disp      = first_r;
    marker    = 1'b0;
    case (phase_r)
      fmts_pkg::PH_HOLD: begin
        if (key_any) begin
          if (freq_cur < cfg.band_low_khz || freq_cur > cfg.band_high_khz) begin
            freq_nxt = item.up_pressed ? cfg.band_low_khz : cfg.band_high_khz;
          end
          phase_nxt = fmts_pkg::PH_TUNE;
          marker    = 1'b1;
          last_nxt  = item.now_ticks;
        end
      end
      fmts_pkg::PH_TUNE: begin
        if (key_any) begin
          step_nxt = item.up_pressed ? $signed({1'b0, cfg.seek_step_khz})
                                     : -$signed({1'b0, cfg.seek_step_khz});
          if (elapsed >= cfg.fast_hold_ticks) begin
            phase_nxt = fmts_pkg::PH_FAST;
          end
        end else if (elapsed >= cfg.step_interval_ticks) begin
          last_nxt  = item.now_ticks;
          freq_nxt  = stepped;
          disp      = 1'b1;
          tune      = 1'b1;
          phase_nxt = fmts_pkg::PH_CHECK;
        end
      end
      fmts_pkg::PH_CHECK: begin
        if (item.tuner_locked && item.station_present && elapsed >= cfg.settle_ticks) begin
          // off-center in the seek direction: keep going
          if (step_pos && item.freq_too_high) begin
            phase_nxt = fmts_pkg::PH_TUNE;
          end else if (step_neg && !item.freq_not_low) begin
            phase_nxt = fmts_pkg::PH_TUNE;
          end else begin
            phase_nxt = fmts_pkg::PH_HOLD;
          end
        end else if (elapsed >= cfg.station_timeout_ticks) begin
          phase_nxt = fmts_pkg::PH_TUNE;
        end
      end
      fmts_pkg::PH_FAST: begin
        if (elapsed >= FAST_IVL) begin
          last_nxt = item.now_ticks;
          freq_nxt = stepped;
          disp     = 1'b1;
        end else if (((!item.up_pressed && step_pos) || (!item.down_pressed && step_neg))
                     && on_50k) begin
          phase_nxt = fmts_pkg::PH_TUNE;
        end
      end
      default: begin
        phase_nxt = fmts_pkg::PH_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fmts_pkg::PH_HOLD;
      freq_r  <= 17'd0;
      step_r  <= 11'sd0;
      last_r  <= 16'd0;
      first_r <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      freq_r  <= freq_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
      first_r <= 1'b0;
    end
  end

  assign result.frequency_khz  = freq_nxt;
  assign result.tune_request   = tune;
  assign result.display_update = disp;
  assign result.seek_marker    = marker;
  assign result.seek_phase     = fmts_pkg::phase_code(phase_nxt);

endmodule

/* rtl/fm_tuner_seek_controller_top.sv */
// Top level of the FM tuner seek controller: input register, seek core,
// result register and configuration port. Depends on fmts_pkg, fmts_cfg, fmts_core.

// One sample in, one result out. Samples are taken at one per clock unless
// in_stall is high; each passes through the input register, then the result
// register, which offers its result on out_valid until out_stall is low; the seek
// state advances in the single pass between the two. The input register keeps
// taking samples while a finished result waits on out_stall, until both
// registers are full. No clearing pass after reset; configuration registers may
// be written through the APB port while idle and read back at any time (byte
// address 4 * register index).
module fm_tuner_seek_controller_top #(
  parameter int FAST_INTERVAL_TICKS = 195
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fmts_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  fmts_pkg::cfg_t      cfg;
  fmts_pkg::in_item_t  in_data_r;
  fmts_pkg::out_item_t result;
  fmts_pkg::out_item_t out_data_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;

  fmts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fmts_core #(
    .FAST_INTERVAL_TICKS (FAST_INTERVAL_TICKS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  // sample moves from input register to result register
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a seek start always lands in the tune phase
  a_marker_tune: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.seek_marker |-> out_data_r.seek_phase == fmts_pkg::PHASE_CODE_TUNE)
    else $error("seek marker outside tune phase");

  // every tune request also refreshes the display
  a_tune_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.tune_request |-> out_data_r.display_update)
    else $error("tune request without display update");

  // a held sample is never dropped from the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_data_r))
    else $error("input register lost a pending sample");

  // a fresh result is loaded only when the result register is free or draining
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !out_valid_r || !out_stall)
    else $error("result register overwritten while stalled");

endmodule
